### src/lep_pkg.sv
// ----------------------------------------------------------------------------
// lep_pkg - output event line parser shared types and constants
// Character codes, number-reader phase codes and the result record.
// ----------------------------------------------------------------------------
package lep_pkg;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // line header "~OUTPUT,"
   localparam int unsigned HEAD_LEN = 8;
   localparam logic [7:0] HEAD_TEXT [HEAD_LEN] =
      '{8'h7E, 8'h4F, 8'h55, 8'h54, 8'h50, 8'h55, 8'h54, 8'h2C};

   localparam logic [6:0] COMMA_MAX = 7'd127;
   localparam logic [6:0] COMMA_MIN = 7'd3;
   localparam logic [2:0] FIELD_MAX = 3'd7;
   localparam logic [2:0] FIELD_ID     = 3'd2;
   localparam logic [2:0] FIELD_ACTION = 3'd3;
   localparam logic [2:0] FIELD_LEVEL  = 3'd4;

   localparam logic [7:0] ACT_ON    = 8'd1;
   localparam logic [7:0] ACT_NINE  = 8'd9;
   localparam logic [7:0] ACT_TEN   = 8'd10;
   localparam logic [7:0] ACT_LEVEL = 8'd32;

   localparam logic [13:0] LEVEL_MAX = 14'd10000;

   // number reader phases
   localparam logic [2:0] PH_GAP   = 3'd0;
   localparam logic [2:0] PH_LEAD  = 3'd1;
   localparam logic [2:0] PH_SIGN  = 3'd2;
   localparam logic [2:0] PH_INT   = 3'd3;
   localparam logic [2:0] PH_FRAC1 = 3'd4;
   localparam logic [2:0] PH_FRAC2 = 3'd5;
   localparam logic [2:0] PH_DONE  = 3'd6;

   typedef struct packed {
      logic [13:0] level_hundredths;
      logic [7:0]  action_code;
      logic [15:0] output_id;
   } result_type;

endpackage

### src/lep_scan.sv
// ----------------------------------------------------------------------------
// lep_scan - line state and field decoder
// Updates the line state for one byte and flags a result on a closing LF.
// ----------------------------------------------------------------------------
module lep_scan
   import lep_pkg::*;
#(
   parameter int LINE_MAX = 127
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output logic       res_valid,
   output result_type res_data
);

   localparam int LC_W = $clog2(LINE_MAX + 1);

   logic [LC_W-1:0] line_count_ff, line_count_in;
   logic            prefix_ok_ff, prefix_ok_in;
   logic [6:0]      comma_total_ff, comma_total_in;
   logic [2:0]      field_index_ff, field_index_in;
   logic [15:0]     id_accum_ff, id_accum_in;
   logic [7:0]      action_accum_ff, action_accum_in;
   logic [13:0]     level_accum_ff, level_accum_in;
   logic [2:0]      number_phase_ff, number_phase_in;

   logic        is_digit, is_blank, dot_ok;
   logic [3:0]  digit;
   logic [2:0]  fidx;
   logic [2:0]  phase;
   logic [19:0] id_next;
   logic [11:0] act_next;
   logic [16:0] lvl_int, lvl_frac1, lvl_frac2;
   logic        action_hit;

   always_comb begin
      is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
      is_blank = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) ||
                 (rx_byte == CH_VT) || (rx_byte == CH_FF);
      digit    = is_digit ? 4'(rx_byte - CH_ZERO) : 4'd0;

      // a non-comma byte in the gap opens the next field
      if (number_phase_ff == PH_GAP) begin
         fidx  = (field_index_ff < FIELD_MAX) ? field_index_ff + 3'd1 : field_index_ff;
         phase = PH_LEAD;
      end else begin
         fidx  = field_index_ff;
         phase = number_phase_ff;
      end
      dot_ok = (rx_byte == CH_DOT) && (fidx == FIELD_LEVEL);

      id_next   = {4'd0, id_accum_ff} * 20'd10 + {16'd0, digit};
      act_next  = {4'd0, action_accum_ff} * 12'd10 + {8'd0, digit};
      lvl_int   = {3'd0, level_accum_ff} * 17'd10 + {13'd0, digit} * 17'd100;
      lvl_frac1 = {3'd0, level_accum_ff} + {13'd0, digit} * 17'd10;
      lvl_frac2 = {3'd0, level_accum_ff} + {13'd0, digit};

      action_hit = (action_accum_ff == ACT_ON) || (action_accum_ff == ACT_NINE) ||
                   (action_accum_ff == ACT_TEN) || (action_accum_ff == ACT_LEVEL);

      line_count_in   = line_count_ff;
      prefix_ok_in    = prefix_ok_ff;
      comma_total_in  = comma_total_ff;
      field_index_in  = field_index_ff;
      id_accum_in     = id_accum_ff;
      action_accum_in = action_accum_ff;
      level_accum_in  = level_accum_ff;
      number_phase_in = number_phase_ff;
      res_valid       = 1'b0;

      res_data.output_id        = id_accum_ff;
      res_data.action_code      = action_accum_ff;
      res_data.level_hundredths = level_accum_ff;

      if (!step || rx_byte == CH_CR || rx_byte == CH_NUL) begin
         // nothing to do
      end else if (rx_byte == CH_LF) begin
         if (line_count_ff != '0) begin
            res_valid = prefix_ok_ff && (line_count_ff >= LC_W'(HEAD_LEN)) &&
                        (comma_total_ff >= COMMA_MIN) && action_hit;
            line_count_in   = '0;
            prefix_ok_in    = 1'b1;
            comma_total_in  = '0;
            field_index_in  = '0;
            id_accum_in     = '0;
            action_accum_in = '0;
            level_accum_in  = '0;
            number_phase_in = PH_GAP;
         end
      end else if (line_count_ff < LC_W'(LINE_MAX)) begin
         if (line_count_ff < LC_W'(HEAD_LEN) && rx_byte != HEAD_TEXT[line_count_ff[2:0]])
            prefix_ok_in = 1'b0;
         line_count_in = line_count_ff + LC_W'(1);

         if (rx_byte == CH_COMMA) begin
            if (comma_total_ff < COMMA_MAX)
               comma_total_in = comma_total_ff + 7'd1;
            number_phase_in = PH_GAP;
         end else begin
            field_index_in  = fidx;
            number_phase_in = PH_DONE;
            case (phase)
               PH_LEAD, PH_SIGN, PH_INT: begin
                  if (phase == PH_LEAD && is_blank) begin
                     number_phase_in = PH_LEAD;
                  end else if (phase == PH_LEAD && rx_byte == CH_PLUS) begin
                     number_phase_in = PH_SIGN;
                  end else if (is_digit) begin
                     number_phase_in = PH_INT;
                     case (fidx)
                        FIELD_ID:
                           id_accum_in = (id_next > 20'd65535) ? 16'hFFFF : id_next[15:0];
                        FIELD_ACTION:
                           action_accum_in = (act_next > 12'd255) ? 8'hFF : act_next[7:0];
                        FIELD_LEVEL:
                           level_accum_in = (lvl_int > {3'd0, LEVEL_MAX}) ?
                                            LEVEL_MAX : lvl_int[13:0];
                        default: ;
                     endcase
                  end else if (dot_ok) begin
                     number_phase_in = PH_FRAC1;
                  end
               end
               PH_FRAC1: begin
                  if (is_digit) begin
                     number_phase_in = PH_FRAC2;
                     if (fidx == FIELD_LEVEL)
                        level_accum_in = (lvl_frac1 > {3'd0, LEVEL_MAX}) ?
                                         LEVEL_MAX : lvl_frac1[13:0];
                  end
               end
               PH_FRAC2: begin
                  if (is_digit && fidx == FIELD_LEVEL)
                     level_accum_in = (lvl_frac2 > {3'd0, LEVEL_MAX}) ?
                                      LEVEL_MAX : lvl_frac2[13:0];
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff   <= '0;
         prefix_ok_ff    <= 1'b1;
         comma_total_ff  <= '0;
         field_index_ff  <= '0;
         id_accum_ff     <= '0;
         action_accum_ff <= '0;
         level_accum_ff  <= '0;
         number_phase_ff <= PH_GAP;
      end else begin
         line_count_ff   <= line_count_in;
         prefix_ok_ff    <= prefix_ok_in;
         comma_total_ff  <= comma_total_in;
         field_index_ff  <= field_index_in;
         id_accum_ff     <= id_accum_in;
         action_accum_ff <= action_accum_in;
         level_accum_ff  <= level_accum_in;
         number_phase_ff <= number_phase_in;
      end
   end

endmodule

### src/lep_rsp.sv
// ----------------------------------------------------------------------------
// lep_rsp - result register
// Holds one finished result until the receiver takes it.
// ----------------------------------------------------------------------------
module lep_rsp
   import lep_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   input  logic       out_ready,
   output logic       out_valid,
   output result_type out_data,
   output logic       slot_free
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign slot_free = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff && !out_ready;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### src/output_event_line_parser_unit.sv
// ----------------------------------------------------------------------------
// output_event_line_parser_unit - text line parser for output events
// Assembles text lines and reports id, action and level of output lines.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one received text byte per request in req_tdata.
//   rsp channel: one result per qualifying "~OUTPUT," line, issued for the
//   closing LF; other bytes and lines give nothing.
//   A byte is taken into an input register, decoded by the line scanner and
//   any result is registered in the output register that drives rsp_tvalid.
//   Throughput is one byte per cycle while the output register is free or
//   being taken: the scanner updates its counters and accumulators (one
//   multiply-by-ten-and-add) combinationally for each byte.
//   The input register can take a byte while a result waits; when the
//   receiver stalls with a result held, one byte sits in the input register
//   and req_tready drops until the result is taken.
//   Reset clears the line state, the input register and the output register.
// ----------------------------------------------------------------------------
module output_event_line_parser_unit
   import lep_pkg::*;
#(
   parameter int LINE_MAX = 127
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [15:0] output_id, [23:16] action_code,
                                    // [37:24] level_hundredths, [39:38] zero
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       slot_free, advance;
   logic       res_valid;
   result_type res_data, out_data;

   assign advance    = in_valid_ff && slot_free;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff && !advance;
      in_byte_in  = in_byte_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         in_valid_ff <= 1'b0;
      else
         in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   lep_scan #(
      .LINE_MAX(LINE_MAX)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .rx_byte  (in_byte_ff),
      .res_valid(res_valid),
      .res_data (res_data)
   );

   lep_rsp u_rsp (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && res_valid),
      .load_data(res_data),
      .out_ready(rsp_tready),
      .out_valid(rsp_tvalid),
      .out_data (out_data),
      .slot_free(slot_free)
   );

   assign rsp_tdata = {2'b00, out_data};

endmodule

### src/lep_check.sv
// ----------------------------------------------------------------------------
// lep_check - port-level checks for the output event line parser
// Watches the result channel for stall behavior and legal result values.
// ----------------------------------------------------------------------------
module lep_check (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // nothing is pending right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_action_set: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[23:16] == 8'd1) || (rsp_tdata[23:16] == 8'd9) ||
                     (rsp_tdata[23:16] == 8'd10) || (rsp_tdata[23:16] == 8'd32))
      else $error("result with unreported action");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[37:24] <= 14'd10000) && (rsp_tdata[39:38] == 2'b00))
      else $error("level out of range");

endmodule

bind output_event_line_parser_unit lep_check u_lep_check (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
